>>> rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Command codes on the cmd field
	localparam logic [2:0] CMD_PUT   = 3'd0;
	localparam logic [2:0] CMD_SETCUR = 3'd1;
	localparam logic [2:0] CMD_HIDE  = 3'd2;
	localparam logic [2:0] CMD_SHOW  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// Control bytes handled by put byte
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Attribute limits
	localparam logic [7:0] COLOR_MAX   = 8'h8F;
	localparam logic [7:0] RESET_COLOR = 8'h07;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = 1;

	// Work kinds produced by the front
	typedef enum logic [3:0] {
		OP_PLAIN,
		OP_NEWLINE,
		OP_CR,
		OP_BS,
		OP_SETCUR,
		OP_HIDE,
		OP_SHOW,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_kind_t;

	// One classified request
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  chr;
		logic [4:0]  row;
		logic [6:0]  col;
		logic        bad;
	} op_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_BLANK,
		ST_SCROLL,
		ST_FILL,
		ST_RESP
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/text_console_writer.sv
// Top level of the text console writer: front, queue and back.
//
//   channel  direction  handshake             fields
//   in       to block   in_valid / in_stall   cmd ch row col
//   out      from block out_valid / out_stall status cursor_row cursor_col
//                                             cursor_hidden cursor_offset
//                                             cell_char cell_color
//   cfg      to block   cfg_we                cfg_wdata (text color)
//
// In the back end a backspace adds a blanking step, except at the origin.
// Scroll walks the cell store through its single read and write port: it copies
// every row but the top one up one row, then fills the bottom row. Clear fills
// every cell. Both fills run only while the text color is valid. After reset a
// clearing pass sets every cell to a space in color 7; no request is taken
// during it.
// The front stage and a two-entry queue take requests while the back works;
// a stalled result holds in the output register while the back goes on.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [7:0]  ch,
	input  wire logic [4:0]  row,
	input  wire logic [6:0]  col,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [4:0]       cursor_row,
	output logic [6:0]       cursor_col,
	output logic             cursor_hidden,
	output logic [11:0]      cursor_offset,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_color
);

	logic init_busy;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	op_t  push_op;
	op_t  head_op;

	// Accept and classify
	tcw_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.ch        (ch),
		.row       (row),
		.col       (col),
		.init_busy (init_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op)
	);

	// Decouple front and back
	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.pop     (q_pop),
		.head_op (head_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Carry out requests on cursor and cells
	tcw_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_empty       (q_empty),
		.q_op          (head_op),
		.q_pop         (q_pop),
		.init_busy     (init_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.cursor_row    (cursor_row),
		.cursor_col    (cursor_col),
		.cursor_hidden (cursor_hidden),
		.cursor_offset (cursor_offset),
		.cell_char     (cell_char),
		.cell_color    (cell_color)
	);

endmodule

`default_nettype wire

>>> rtl/tcw_front.sv
// Front end: accepts requests, classifies them and checks positions.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] ch,
	input  wire logic [4:0] row,
	input  wire logic [6:0] col,
	input  wire logic       init_busy,
	input  wire logic       q_full,
	output logic            q_push,
	output op_t             q_op
);

	logic valid_s1;
	op_t  op_s1;
	op_t  dec;
	logic ready;
	logic accept;
	logic pos_ok;

	// Stage is free when empty or draining into the queue
	assign ready    = !valid_s1 || !q_full;
	assign in_stall = !ready || init_busy;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_op     = op_s1;

	assign pos_ok = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));

	// Classify the request
	always_comb begin
		dec.kind = OP_NOP;
		dec.chr  = ch;
		dec.row  = row;
		dec.col  = col;
		dec.bad  = 1'b0;
		unique case (cmd)
			CMD_PUT: begin
				unique case (ch)
					CH_NL: dec.kind = OP_NEWLINE;
					CH_CR: dec.kind = OP_CR;
					CH_BS: dec.kind = OP_BS;
					CH_TAB: begin
						dec.kind = OP_PLAIN;
						dec.chr  = CH_SPACE;
					end
					default: dec.kind = OP_PLAIN;
				endcase
			end
			CMD_SETCUR: begin
				dec.kind = OP_SETCUR;
				dec.bad  = !pos_ok;
			end
			CMD_HIDE:  dec.kind = OP_HIDE;
			CMD_SHOW:  dec.kind = OP_SHOW;
			CMD_CLEAR: dec.kind = OP_CLEAR;
			CMD_READ: begin
				dec.kind = OP_READ;
				dec.bad  = !pos_ok;
			end
			default: dec.kind = OP_NOP;
		endcase
	end

	// Hold the stage valid until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

>>> rtl/tcw_queue.sv
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue import tcw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	input  wire logic pop,
	output op_t       head_op,
	output logic      full,
	output logic      empty
);

	op_t              entry_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     count_q;

	assign full    = (count_q == (QPW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head_op = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

>>> rtl/tcw_back.sv
// Back end: cursor, cell store, scroll and clear sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        q_empty,
	input  wire op_t         q_op,
	output logic             q_pop,
	output logic             init_busy,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [4:0]       cursor_row,
	output logic [6:0]       cursor_col,
	output logic             cursor_hidden,
	output logic [11:0]      cursor_offset,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_color
);

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int SW     = $clog2(NCELLS + 1);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLS);

	back_state_t    state_q, state_d;
	logic [RW-1:0]  cur_row_q;
	logic [CW-1:0]  cur_col_q;
	logic           cur_hidden_q;
	logic [7:0]     text_color_q;
	logic [AW-1:0]  fill_q;
	logic [SW-1:0]  src_q;
	logic [AW-1:0]  dst_q;
	logic           pend_q;
	logic           resp_status_q;
	logic           resp_read_q;
	logic           out_valid_q;

	logic [15:0]    mem [NCELLS];
	logic [15:0]    rdata_q;
	logic           mem_we;
	logic [AW-1:0]  waddr;
	logic [15:0]    wdata;
	logic           mem_re;
	logic [AW-1:0]  raddr;

	logic           color_ok;
	logic           row_last;
	logic           col_last;
	logic           at_origin;
	logic           src_done;
	logic           fill_done;
	logic           out_free;
	logic           out_load;
	logic [AW-1:0]  cur_addr;
	logic [AW-1:0]  op_addr;
	logic [15:0]    offset;

	assign color_ok  = (text_color_q <= COLOR_MAX);
	assign row_last  = (cur_row_q == RW'(ROWS - 1));
	assign col_last  = (cur_col_q == CW'(COLS - 1));
	assign at_origin = (cur_row_q == '0) && (cur_col_q == '0);
	assign src_done  = (src_q == SW'(NCELLS));
	assign fill_done = (fill_q == AW'(NCELLS - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign init_busy = (state_q == ST_INIT);
	assign out_valid = out_valid_q;

	assign cur_addr = AW'(AW'(cur_row_q) * AW'(COLS)) + AW'(cur_col_q);
	assign op_addr  = AW'(AW'(RW'(q_op.row)) * AW'(COLS)) + AW'(CW'(q_op.col));
	assign offset   = (16'(cur_row_q) + (cur_hidden_q ? 16'(ROWS) : 16'd0)) * 16'(COLS)
		+ 16'(cur_col_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (fill_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (q_op.kind)
						OP_PLAIN:   state_d = (col_last && row_last) ? ST_SCROLL : ST_RESP;
						OP_NEWLINE: state_d = row_last ? ST_SCROLL : ST_RESP;
						OP_BS:      state_d = at_origin ? ST_RESP : ST_BLANK;
						OP_CLEAR:   state_d = color_ok ? ST_FILL : ST_RESP;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_BLANK: state_d = ST_RESP;
			ST_SCROLL: begin
				if (src_done) begin
					state_d = color_ok ? ST_FILL : ST_RESP;
				end
			end
			ST_FILL: begin
				if (fill_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port and handshake controls
	always_comb begin
		mem_we   = 1'b0;
		waddr    = cur_addr;
		wdata    = {text_color_q, CH_SPACE};
		mem_re   = 1'b0;
		raddr    = op_addr;
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				waddr  = fill_q;
				wdata  = {RESET_COLOR, CH_SPACE};
			end
			ST_IDLE: begin
				q_pop = !q_empty;
				if (!q_empty) begin
					unique case (q_op.kind)
						OP_PLAIN: begin
							mem_we = color_ok;
							wdata  = {text_color_q, q_op.chr};
						end
						OP_READ:  mem_re = !q_op.bad;
						default: ;
					endcase
				end
			end
			ST_BLANK: mem_we = color_ok;
			ST_SCROLL: begin
				mem_re = !src_done;
				raddr  = src_q[AW-1:0];
				mem_we = pend_q;
				waddr  = dst_q;
				wdata  = rdata_q;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				waddr  = fill_q;
			end
			ST_RESP:  out_load = out_free;
			default: ;
		endcase
	end

	// Cell store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Cursor, counters and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			cur_hidden_q  <= 1'b0;
			text_color_q  <= RESET_COLOR;
			fill_q        <= '0;
			src_q         <= '0;
			dst_q         <= '0;
			pend_q        <= 1'b0;
			resp_status_q <= 1'b0;
			resp_read_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_INIT: begin
					fill_q <= fill_q + AW'(1);
				end
				ST_IDLE: begin
					src_q  <= SW'(COLS);
					dst_q  <= '0;
					pend_q <= 1'b0;
					if (!q_empty) begin
						fill_q        <= (q_op.kind == OP_CLEAR) ? '0 : AW'(NCELLS - COLS);
						resp_status_q <= q_op.bad;
						resp_read_q   <= (q_op.kind == OP_READ) && !q_op.bad;
						unique case (q_op.kind)
							OP_PLAIN: begin
								if (col_last) begin
									cur_col_q <= '0;
									if (!row_last) begin
										cur_row_q <= cur_row_q + RW'(1);
									end
								end else begin
									cur_col_q <= cur_col_q + CW'(1);
								end
							end
							OP_NEWLINE: begin
								cur_col_q <= '0;
								if (!row_last) begin
									cur_row_q <= cur_row_q + RW'(1);
								end
							end
							OP_CR: cur_col_q <= '0;
							OP_BS: begin
								if (!at_origin) begin
									if (cur_col_q == '0) begin
										cur_row_q <= cur_row_q - RW'(1);
										cur_col_q <= CW'(COLS - 1);
									end else begin
										cur_col_q <= cur_col_q - CW'(1);
									end
								end
							end
							OP_SETCUR: begin
								if (!q_op.bad) begin
									cur_row_q <= RW'(q_op.row);
									cur_col_q <= CW'(q_op.col);
								end
							end
							OP_HIDE: cur_hidden_q <= 1'b1;
							OP_SHOW: cur_hidden_q <= 1'b0;
							OP_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCROLL: begin
					// Read one row ahead, write the previous read back
					if (!src_done) begin
						src_q <= src_q + SW'(1);
					end
					if (pend_q) begin
						dst_q <= dst_q + AW'(1);
					end
					pend_q <= !src_done;
				end
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status        <= resp_status_q;
			cursor_row    <= 5'(cur_row_q);
			cursor_col    <= 7'(cur_col_q);
			cursor_hidden <= cur_hidden_q;
			cursor_offset <= offset[11:0];
			cell_char     <= resp_read_q ? rdata_q[7:0] : 8'd0;
			cell_color    <= resp_read_q ? rdata_q[15:8] : 8'd0;
		end
	end

	// Cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_row_q) < 32'(ROWS)) && (32'(cur_col_q) < 32'(COLS)))
		else $error("cursor out of range");

	// The reset clearing pass runs only once
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_INIT) |=> (state_q != ST_INIT))
		else $error("clearing pass re-entered");

	// Scroll copy keeps write one row plus one behind the read pointer
	a_scroll_lag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && pend_q) |->
		(32'(src_q) == 32'(dst_q) + 32'(COLS) + 32'd1))
		else $error("scroll copy misaligned");

	// A result appears only after the response state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
		else $error("result without response state");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the text console writer: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
	import tcw_pkg::*;

	localparam int ROWS = 25;
	localparam int COLS = 80;
	localparam int NCELLS = ROWS * COLS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 85;
	localparam int SETTLE_CYCLES = 200;

	// Commands with no function; the block answers them with the cursor only
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} console_req_t;

	typedef struct packed {
		logic        status;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic        cursor_hidden;
		logic [11:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_color;
	} cursor_report_t;

	typedef struct {
		console_req_t   rq;
		bit             known;
		cursor_report_t res;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [7:0]  ch;
	logic [4:0]  row;
	logic [6:0]  col;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic        cursor_hidden;
	logic [11:0] cursor_offset;
	logic [7:0]  cell_char;
	logic [7:0]  cell_color;

	// Shadow copy of the console: cell store, cursor, hidden flag, pen color
	logic [15:0] shadow_cells [NCELLS];
	logic [4:0]  cur_r;
	logic [6:0]  cur_c;
	logic        cur_hidden;
	logic [7:0]  pen_color;

	cursor_report_t cursor_reports[$];
	plan_row_t      directed_plan[$];

	int  mismatch_count;
	int  commands_sent;
	int  reports_checked;
	int  scroll_count;
	int  cell_reads;
	int  rejected_count;
	int  quiet_cycles;
	bit  sender_burst;
	int  receiver_calm;
	int  stall_left;

	text_console_writer #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.ch(ch),
		.row(row),
		.col(col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.cursor_hidden(cursor_hidden),
		.cursor_offset(cursor_offset),
		.cell_char(cell_char),
		.cell_color(cell_color)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Draw one cell in the pen color; an invalid color draws nothing
	function automatic void paint(int r, int c, logic [7:0] glyph);
		if (r < ROWS && c < COLS && pen_color <= COLOR_MAX)
			shadow_cells[r * COLS + c] = {pen_color, glyph};
	endfunction

	// Move to the next line, scrolling up one row from the bottom
	function automatic void line_feed();
		if (cur_r >= ROWS - 1) begin
			for (int i = 0; i < NCELLS - COLS; i++)
				shadow_cells[i] = shadow_cells[i + COLS];
			for (int k = 0; k < COLS; k++)
				paint(ROWS - 1, k, CH_SPACE);
			cur_r = 5'(ROWS - 1);
			scroll_count++;
		end else begin
			cur_r = cur_r + 5'd1;
		end
		cur_c = '0;
	endfunction

	// Apply one request to the shadow console and build the report it gives
	function automatic cursor_report_t run_console_cmd(console_req_t rq);
		cursor_report_t rep;
		int line;
		rep = '0;
		case (rq.cmd)
			CMD_PUT: begin
				case (rq.ch)
					CH_NL: line_feed();
					CH_CR: cur_c = '0;
					CH_BS: begin
						if (cur_r != 0 || cur_c != 0) begin
							if (cur_c == 0) begin
								cur_r = cur_r - 5'd1;
								cur_c = 7'(COLS - 1);
							end else begin
								cur_c = cur_c - 7'd1;
							end
							paint(int'(cur_r), int'(cur_c), CH_SPACE);
						end
					end
					default: begin
						paint(int'(cur_r), int'(cur_c), (rq.ch == CH_TAB) ? CH_SPACE : rq.ch);
						if (cur_c >= COLS - 1)
							line_feed();
						else
							cur_c = cur_c + 7'd1;
					end
				endcase
			end
			CMD_SETCUR: begin
				if (rq.row < ROWS && rq.col < COLS) begin
					cur_r = rq.row;
					cur_c = rq.col;
				end else begin
					rep.status = STATUS_REJECT;
				end
			end
			CMD_HIDE: cur_hidden = 1'b1;
			CMD_SHOW: cur_hidden = 1'b0;
			CMD_CLEAR: begin
				for (int i = 0; i < NCELLS; i++)
					paint(i / COLS, i % COLS, CH_SPACE);
				cur_r = '0;
				cur_c = '0;
			end
			CMD_READ: begin
				if (rq.row < ROWS && rq.col < COLS) begin
					{rep.cell_color, rep.cell_char} = shadow_cells[rq.row * COLS + rq.col];
					cell_reads++;
				end else begin
					rep.status = STATUS_REJECT;
				end
			end
			default: ;
		endcase
		line = int'(cur_r) + (cur_hidden ? ROWS : 0);
		rep.cursor_row = cur_r;
		rep.cursor_col = cur_c;
		rep.cursor_hidden = cur_hidden;
		rep.cursor_offset = 12'(line * COLS + int'(cur_c));
		if (rep.status == STATUS_REJECT)
			rejected_count++;
		return rep;
	endfunction

	function automatic void plan_predicted(logic [2:0] c, logic [7:0] b, logic [4:0] r,
			logic [6:0] k);
		plan_row_t p;
		p.rq = '{c, b, r, k};
		p.known = 1'b0;
		p.res = '0;
		directed_plan.push_back(p);
	endfunction

	function automatic void plan_known(logic [2:0] c, logic [7:0] b, logic [4:0] r,
			logic [6:0] k, logic st, logic [4:0] cr, logic [6:0] cc, logic hid,
			logic [11:0] off, logic [7:0] cch, logic [7:0] ccl);
		plan_row_t p;
		p.rq = '{c, b, r, k};
		p.known = 1'b1;
		p.res = '{st, cr, cc, hid, off, cch, ccl};
		directed_plan.push_back(p);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random request: mostly typed text, with cursor moves, reads and the rest
	function automatic console_req_t random_request();
		console_req_t rq;
		int pick;
		int sub;
		rq.cmd = CMD_PUT;
		rq.ch = 8'($urandom);
		rq.row = 5'($urandom);
		rq.col = 7'($urandom);
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		if (pick < 55) begin
			if (sub < 10)
				rq.ch = CH_NL;
			else if (sub < 14)
				rq.ch = CH_CR;
			else if (sub < 22)
				rq.ch = CH_BS;
			else if (sub < 26)
				rq.ch = CH_TAB;
		end else if (pick < 67) begin
			rq.cmd = CMD_SETCUR;
			if (sub >= 15 && sub < 45) begin
				rq.row = 5'(ROWS - 1);
				rq.col = 7'($urandom_range(60, COLS - 1));
			end else if (sub >= 45) begin
				rq.row = 5'($urandom_range(0, ROWS - 1));
				rq.col = 7'($urandom_range(0, COLS - 1));
			end
		end else if (pick < 72) begin
			rq.cmd = CMD_HIDE;
		end else if (pick < 77) begin
			rq.cmd = CMD_SHOW;
		end else if (pick < 79) begin
			rq.cmd = CMD_CLEAR;
		end else if (pick < 97) begin
			rq.cmd = CMD_READ;
			// half the reads look at the lines just typed
			if (sub < 50) begin
				rq.row = (sub < 30 || cur_r == 0) ? cur_r : cur_r - 5'd1;
				rq.col = 7'($urandom_range(0, COLS - 1));
			end
		end else begin
			rq.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE6 : CMD_SPARE7;
		end
		return rq;
	endfunction

	// Present one request and hold it until the block takes it
	task automatic send_request(input console_req_t rq, input bit known,
			input cursor_report_t known_res);
		int gap;
		cursor_report_t predicted;
		gap = sender_burst ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= rq.cmd;
		ch <= rq.ch;
		row <= rq.row;
		col <= rq.col;
		do @(posedge clk); while (in_stall);
		predicted = run_console_cmd(rq);
		cursor_reports.push_back(known ? known_res : predicted);
		commands_sent++;
	endtask

	// Drop valid and hold off until every report is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cursor_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		pen_color = value;
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random stall runs, with calm stretches of no stall
	initial begin
		out_stall = 1'b0;
		receiver_calm = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (receiver_calm > 0)
				receiver_calm--;
			else if ($urandom_range(0, 299) == 0)
				receiver_calm = $urandom_range(50, 400);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (receiver_calm == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted report with the oldest prediction
	always @(posedge clk) begin : check_reports
		cursor_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cursor_reports.size() == 0) begin
				$display("%0t: report with none expected, offset %0d", $time, cursor_offset);
				mismatch_count++;
			end else begin
				want = cursor_reports.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("cursor_row", 16'(want.cursor_row), 16'(cursor_row));
				check_field("cursor_col", 16'(want.cursor_col), 16'(cursor_col));
				check_field("cursor_hidden", 16'(want.cursor_hidden), 16'(cursor_hidden));
				check_field("cursor_offset", 16'(want.cursor_offset), 16'(cursor_offset));
				check_field("cell_char", 16'(want.cell_char), 16'(cell_char));
				check_field("cell_color", 16'(want.cell_color), 16'(cell_color));
				reports_checked++;
			end
		end
	end

	// End the run when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no request or report moved for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] phase_colors [PHASES];
		console_req_t rq;
		int sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = CMD_PUT;
		ch = '0;
		row = '0;
		col = '0;
		quiet_cycles = 0;
		mismatch_count = 0;
		commands_sent = 0;
		reports_checked = 0;
		scroll_count = 0;
		cell_reads = 0;
		rejected_count = 0;
		sender_burst = 1'b0;
		for (int i = 0; i < NCELLS; i++)
			shadow_cells[i] = {RESET_COLOR, CH_SPACE};
		cur_r = '0;
		cur_c = '0;
		cur_hidden = 1'b0;
		pen_color = RESET_COLOR;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, rejected positions, edits, wrap, scroll, clear
		plan_known(CMD_READ, 8'h00, 5'd0, 7'd0, STATUS_OK, 5'd0, 7'd0, 1'b0, 12'd0,
			CH_SPACE, RESET_COLOR);
		plan_known(CMD_READ, 8'h00, 5'd24, 7'd79, STATUS_OK, 5'd0, 7'd0, 1'b0, 12'd0,
			CH_SPACE, RESET_COLOR);
		plan_known(CMD_SETCUR, 8'h00, 5'd25, 7'd0, STATUS_REJECT, 5'd0, 7'd0, 1'b0, 12'd0,
			8'h00, 8'h00);
		plan_known(CMD_SETCUR, 8'h00, 5'd0, 7'd80, STATUS_REJECT, 5'd0, 7'd0, 1'b0, 12'd0,
			8'h00, 8'h00);
		plan_known(CMD_READ, 8'hFF, 5'd31, 7'd127, STATUS_REJECT, 5'd0, 7'd0, 1'b0, 12'd0,
			8'h00, 8'h00);
		// backspace at the origin leaves everything alone
		plan_known(CMD_PUT, CH_BS, 5'd0, 7'd0, STATUS_OK, 5'd0, 7'd0, 1'b0, 12'd0,
			8'h00, 8'h00);
		plan_predicted(CMD_PUT, 8'h41, 5'd0, 7'd0);
		plan_predicted(CMD_PUT, 8'hFF, 5'd0, 7'd0);
		plan_predicted(CMD_PUT, 8'h00, 5'd0, 7'd0);
		plan_predicted(CMD_PUT, CH_TAB, 5'd0, 7'd0);
		plan_predicted(CMD_PUT, CH_BS, 5'd0, 7'd0);
		plan_predicted(CMD_READ, 8'h00, 5'd0, 7'd1);
		plan_known(CMD_PUT, CH_CR, 5'd0, 7'd0, STATUS_OK, 5'd0, 7'd0, 1'b0, 12'd0,
			8'h00, 8'h00);
		plan_known(CMD_HIDE, 8'h00, 5'd0, 7'd0, STATUS_OK, 5'd0, 7'd0, 1'b1, 12'd2000,
			8'h00, 8'h00);
		plan_known(CMD_SETCUR, 8'h00, 5'd24, 7'd79, STATUS_OK, 5'd24, 7'd79, 1'b1,
			12'd3999, 8'h00, 8'h00);
		// last cell: wrap and scroll in one byte
		plan_predicted(CMD_PUT, 8'h5A, 5'd0, 7'd0);
		plan_predicted(CMD_READ, 8'h00, 5'd23, 7'd79);
		plan_predicted(CMD_PUT, CH_NL, 5'd0, 7'd0);
		plan_predicted(CMD_READ, 8'h00, 5'd22, 7'd79);
		// backspace at column zero climbs to the row above
		plan_predicted(CMD_PUT, CH_BS, 5'd0, 7'd0);
		plan_predicted(CMD_SHOW, 8'h00, 5'd0, 7'd0);
		plan_predicted(CMD_SETCUR, 8'h00, 5'd5, 7'd0);
		plan_predicted(CMD_PUT, CH_BS, 5'd0, 7'd0);
		plan_known(CMD_CLEAR, 8'h00, 5'd0, 7'd0, STATUS_OK, 5'd0, 7'd0, 1'b0, 12'd0,
			8'h00, 8'h00);
		plan_predicted(CMD_READ, 8'h00, 5'd22, 7'd79);
		plan_predicted(CMD_SPARE6, 8'hFF, 5'd31, 7'd127);
		plan_predicted(CMD_SPARE7, 8'h00, 5'd0, 7'd0);
		foreach (directed_plan[i])
			send_request(directed_plan[i].rq, directed_plan[i].known, directed_plan[i].res);

		// Random phases, each under its own text color, extremes and invalid ones included
		phase_colors[0] = 8'h00;
		phase_colors[1] = COLOR_MAX;
		phase_colors[2] = COLOR_MAX + 8'd1;
		phase_colors[3] = 8'($urandom_range(1, COLOR_MAX - 1));
		phase_colors[4] = 8'hFF;
		phase_colors[5] = 8'($urandom);
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_color(phase_colors[p]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent % 40 == 0)
					sender_burst = ($urandom_range(0, 3) == 0);
				rq = random_request();
				send_request(rq, 1'b0, '0);
				if (rq.cmd != CMD_SPARE6 && rq.cmd != CMD_SPARE7)
					sent++;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d commands and %0d checked reports under %0d text colors.",
			commands_sent, reports_checked, PHASES + 1);
		$display("It saw %0d scrolls, %0d cell reads and %0d rejected positions.",
			scroll_count, cell_reads, rejected_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
sim/testbench.sv
